// ===== design/lbbt_pkg.sv =====
// Package: shared widths, register indexes and state/config types for the LED blink timer.
`timescale 1ns / 1ps

package lbbt_pkg;

    // Width of the phase timer; the elapsed count carries one extra bit
    localparam int TIME_BITS = 16;
    localparam int ELAPSED_BITS = TIME_BITS + 1;

    // Configuration port geometry
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 3;

    // Register reset values
    localparam logic [CFG_DATA_BITS-1:0] CONT_OFF_RESET = 16'd1000;
    localparam logic [CFG_DATA_BITS-1:0] CONT_ON_RESET = 16'd0;
    localparam logic [CFG_DATA_BITS-1:0] BURST_OFF_RESET = 16'd100;
    localparam logic [CFG_DATA_BITS-1:0] BURST_ON_RESET = 16'd100;

    // Request function codes
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_BURST = 1'b1;

    typedef logic [TIME_BITS-1:0] len_t;
    typedef logic [ELAPSED_BITS-1:0] elapsed_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CONT_OFF  = 3'd0,
        REG_CONT_ON   = 3'd1,
        REG_BURST_OFF = 3'd2,
        REG_BURST_ON  = 3'd3,
        REG_INVERT    = 3'd4,
        REG_ENABLE    = 3'd5
    } reg_index_t;

    // Configuration as seen by the step logic
    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] cont_off_ms;
        logic [CFG_DATA_BITS-1:0] cont_on_ms;
        logic [CFG_DATA_BITS-1:0] burst_off_ms;
        logic [CFG_DATA_BITS-1:0] burst_on_ms;
        logic                     invert_out;
        logic                     led_enable;
    } cfg_t;

    // Running pattern state
    typedef struct packed {
        elapsed_t   elapsed_ticks;
        logic       cont_phase_on;
        logic       burst_phase_on;
        logic [7:0] blinks_left;
        logic       logical_level;
    } state_t;

    localparam elapsed_t ELAPSED_MAX = {ELAPSED_BITS{1'b1}};

endpackage

// ===== design/lbbt_if.sv =====
// Interfaces: request and result channels of the LED blink timer.
`timescale 1ns / 1ps

interface lbbt_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] burst_count;

    modport source (output valid, output func, output burst_count, input ready);
    modport sink (input valid, input func, input burst_count, output ready);
endinterface

interface lbbt_rsp_if;
    logic       valid;
    logic       ready;
    logic       led_level;
    logic       burst_active;
    logic [7:0] burst_left;

    modport source (output valid, output led_level, output burst_active,
                    output burst_left, input ready);
    modport sink (input valid, input led_level, input burst_active,
                  input burst_left, output ready);
endinterface

// ===== design/lbbt_step.sv =====
// Step logic: next pattern state for one tick or burst start request.
`timescale 1ns / 1ps

module lbbt_step
(
    input  lbbt_pkg::cfg_t   cfg,
    input  lbbt_pkg::state_t cur,
    input  logic             func,
    input  logic [7:0]       burst_count,
    output lbbt_pkg::state_t nxt
);

    lbbt_pkg::elapsed_t el_inc;
    lbbt_pkg::len_t     off_len;
    lbbt_pkg::len_t     on_len;
    lbbt_pkg::len_t     cur_len;
    lbbt_pkg::len_t     next_len;
    logic               in_burst;
    logic               phase_on;
    logic               phase_end;
    logic [7:0]         blinks_dec;

    // Select the active phase machine and its lengths
    always_comb
    begin
        in_burst = (cur.blinks_left != 8'd0);
        phase_on = in_burst ? cur.burst_phase_on : cur.cont_phase_on;
        off_len = in_burst ? lbbt_pkg::TIME_BITS'(cfg.burst_off_ms)
                           : lbbt_pkg::TIME_BITS'(cfg.cont_off_ms);
        on_len = in_burst ? lbbt_pkg::TIME_BITS'(cfg.burst_on_ms)
                          : lbbt_pkg::TIME_BITS'(cfg.cont_on_ms);
        cur_len = phase_on ? on_len : off_len;
        next_len = phase_on ? off_len : on_len;
        el_inc = (cur.elapsed_ticks == lbbt_pkg::ELAPSED_MAX)
                 ? cur.elapsed_ticks : cur.elapsed_ticks + 1'b1;
        phase_end = (el_inc > {1'b0, cur_len});
        blinks_dec = cur.blinks_left - 8'd1;
    end

    // Apply a burst start, or advance the pattern by one tick while the LED is enabled
    always_comb
    begin
        nxt = cur;
        if (func == lbbt_pkg::FUNC_BURST)
        begin
            nxt.blinks_left = burst_count;
            nxt.burst_phase_on = 1'b0;
            nxt.elapsed_ticks = '0;
            if (cfg.led_enable)
            begin
                nxt.logical_level = 1'b0;
            end
        end
        else if (cfg.led_enable)
        begin
            nxt.elapsed_ticks = el_inc;
            if (phase_end)
            begin
                nxt.elapsed_ticks = el_inc - {1'b0, cur_len};
                if (next_len != '0)
                begin
                    nxt.logical_level = !phase_on;
                end
                if (in_burst)
                begin
                    nxt.burst_phase_on = !cur.burst_phase_on;
                    // Count a blink when its on phase ends
                    if (phase_on)
                    begin
                        nxt.blinks_left = blinks_dec;
                        if (blinks_dec == 8'd0)
                        begin
                            nxt.cont_phase_on = 1'b0;
                        end
                    end
                end
                else
                begin
                    nxt.cont_phase_on = !cur.cont_phase_on;
                end
            end
        end
    end

endmodule

// ===== design/led_blink_burst_timer.sv =====
// Top level: LED blink timer with burst override, config registers and result register.
//
// Usage:
//   req carries one request per handshake: func 0 is a one millisecond tick,
//   func 1 starts a burst of burst_count blinks. Every request yields exactly
//   one result on rsp: the LED pin level, whether a burst is running and the
//   blinks left, all taken after the request is applied.
//   Latency: the result is valid the cycle after the request is accepted.
//   Throughput: one request per cycle; the pattern update is a single
//   increment, compare and subtract on the elapsed counter.
//   A held result does not stop the next request while the receiver takes
//   results every cycle; ready drops only when the result register is full
//   and the receiver stalls, and rises again as soon as it is taken.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 cont_off, 1 cont_on, 2 burst_off, 3 burst_on, 4 invert, 5 enable);
//   other indexes are ignored. Write only while the block is idle.
//   Reset: lengths return to 1000/0/100/100 ticks, inversion off, LED
//   enabled, the pattern restarts in the continuous off phase with the LED
//   off, and no result is pending.
`timescale 1ns / 1ps

module led_blink_burst_timer
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    lbbt_req_if.sink                              req,
    lbbt_rsp_if.source                            rsp,
    input  logic                                  cfg_we,
    input  logic [lbbt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [lbbt_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    lbbt_pkg::cfg_t   cfg_reg;
    lbbt_pkg::cfg_t   cfg_next;
    lbbt_pkg::state_t state_reg;
    lbbt_pkg::state_t state_next;
    logic             rsp_valid_reg;
    logic             led_level_reg;
    logic             burst_active_reg;
    logic [7:0]       burst_left_reg;
    logic             req_accept;

    // Accept a request whenever the result register is free or being drained
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_accept = req.valid && req.ready;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (lbbt_pkg::reg_index_t'(cfg_index))
                lbbt_pkg::REG_CONT_OFF:  cfg_next.cont_off_ms = cfg_data;
                lbbt_pkg::REG_CONT_ON:   cfg_next.cont_on_ms = cfg_data;
                lbbt_pkg::REG_BURST_OFF: cfg_next.burst_off_ms = cfg_data;
                lbbt_pkg::REG_BURST_ON:  cfg_next.burst_on_ms = cfg_data;
                lbbt_pkg::REG_INVERT:    cfg_next.invert_out = cfg_data[0];
                lbbt_pkg::REG_ENABLE:    cfg_next.led_enable = cfg_data[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    // Compute the next pattern state for the incoming request
    lbbt_step u_step
    (
        .cfg         (cfg_reg),
        .cur         (state_reg),
        .func        (req.func),
        .burst_count (req.burst_count),
        .nxt         (state_next)
    );

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cont_off_ms <= lbbt_pkg::CONT_OFF_RESET;
            cfg_reg.cont_on_ms <= lbbt_pkg::CONT_ON_RESET;
            cfg_reg.burst_off_ms <= lbbt_pkg::BURST_OFF_RESET;
            cfg_reg.burst_on_ms <= lbbt_pkg::BURST_ON_RESET;
            cfg_reg.invert_out <= 1'b0;
            cfg_reg.led_enable <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Advance pattern state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (req_accept)
        begin
            state_reg <= state_next;
        end
    end

    // Track result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req_accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            led_level_reg <= state_next.logical_level ^ cfg_reg.invert_out;
            burst_active_reg <= (state_next.blinks_left != 8'd0);
            burst_left_reg <= state_next.blinks_left;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.led_level = led_level_reg;
    assign rsp.burst_active = burst_active_reg;
    assign rsp.burst_left = burst_left_reg;

endmodule
